// File: hdl/trimmed_mean_ph_filter_assert.svh
// assertion macros for the trimmed mean ph filter
`ifndef TRIMMED_MEAN_PH_FILTER_ASSERT_SVH
`define TRIMMED_MEAN_PH_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
`define TMPH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tmph check failed");
`define TMPH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tmph check failed");
`else
`define TMPH_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TMPH_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/tmph_pkg.sv
// shared types and constants of the trimmed mean ph filter
`default_nettype none

package tmph_pkg;

    localparam int ADC_W     = 12;
    localparam int SUM_OUT_W = 15;
    localparam int PH_W      = 11;

    localparam logic [SUM_OUT_W-1:0] SUM_MAX = '1;
    localparam logic [PH_W-1:0]      PH_MAX  = '1;

    // 5 V * 3.5 pH/V * 100 over 6024 counts
    localparam int unsigned PH_NUM    = 1750;
    localparam int unsigned PH_COUNTS = 6024;

    typedef struct packed {
        logic ins;
        logic clr;
    } t_cell_ctl;

    typedef struct packed {
        logic gt;
        logic valid;
    } t_link;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// File: hdl/tmph_cell.sv
// one cell of the insertion sorting chain
`default_nettype none

module tmph_cell import tmph_pkg::*; #(
    parameter int W = 12
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cell_ctl    i_ctl,
    input  wire logic [W-1:0] i_x,
    input  wire t_link        i_left,
    input  wire logic [W-1:0] i_left_value,
    output t_link             o_link,
    output logic [W-1:0]      o_value,
    output logic [W-1:0]      o_next_value
);

    logic [W-1:0] r_value;
    logic         r_valid;
    logic         w_gt;
    logic         n_valid;

    assign w_gt = !r_valid || (r_value > i_x);

    always_comb begin
        o_next_value = r_value;
        n_valid      = r_valid;
        if (i_ctl.ins && w_gt) begin
            o_next_value = i_left.gt ? i_left_value : i_x;
            n_valid      = i_left.gt ? i_left.valid : 1'b1;
        end
        if (i_ctl.clr) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= o_next_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_link.gt    = w_gt;
    assign o_link.valid = r_valid;
    assign o_value      = r_value;

endmodule

`default_nettype wire

// File: hdl/tmph_div.sv
// division by a constant through a reciprocal multiplication, with saturation of the quotient
`default_nettype none

module tmph_div import tmph_pkg::*; #(
    parameter int          NUM_W = 28,
    parameter int          DIV_W = 30,
    parameter int unsigned DEN   = 36144
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_numer,
    output t_div_stat             o_stat,
    output logic [PH_W-1:0]       o_quot
);

    localparam int                 RECIP_W   = NUM_W - $clog2(DEN) + 2;
    localparam int                 PROD_W    = NUM_W + ((RECIP_W > PH_W) ? RECIP_W : PH_W);
    localparam logic [DIV_W-1:0]   SAT_LIM   = DIV_W'(DEN) << PH_W;
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((64'd1 << NUM_W) / 64'(DEN));
    localparam logic [1:0]         LAST_STEP = 2'd3;

    logic [NUM_W-1:0]  r_num;
    logic [PROD_W-1:0] r_prod;
    logic [PH_W-1:0]   r_qe;
    logic [DIV_W-1:0]  r_rem;
    logic [PH_W-1:0]   r_quot;
    logic              r_sat;
    logic [1:0]        r_step;
    logic              r_busy;
    logic              r_done;

    // estimate is the quotient or one below it, the remainder compare fixes it
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_numer;
            r_sat  <= DIV_W'(i_numer) >= SAT_LIM;
            r_step <= LAST_STEP;
        end else if (r_busy) begin
            r_prod <= PROD_W'(r_num) * PROD_W'(RECIP);
            r_qe   <= r_prod[NUM_W +: PH_W];
            r_rem  <= DIV_W'(r_num) - DIV_W'(r_qe) * DIV_W'(DEN);
            r_quot <= r_qe + PH_W'(r_rem >= DIV_W'(DEN));
            r_step <= r_step - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == 2'd0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == 2'd0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_sat ? PH_MAX : r_quot;

endmodule

`default_nettype wire

// File: hdl/trimmed_mean_ph_filter.sv
// Trimmed mean pH filter: samples enter a chain of GROUP_SIZE sorting cells, one transfer per
// cycle while o_in_ready is high, and stay in ascending order as they arrive. The last sample
// of a group loads the sorted values into a shift line and clears the chain, so the next group
// starts at once. The sum of the middle values is then built one value per cycle, multiplied by
// the pH constant and divided by the constant denominator through a reciprocal multiplication
// with one correction step. The first GROUP_SIZE - 1 samples of the next group are taken
// meanwhile at one per cycle, its last sample waits until the result path is free. The result
// sits in an output register until its transfer.
`default_nettype none

`include "trimmed_mean_ph_filter_assert.svh"

module trimmed_mean_ph_filter import tmph_pkg::*; #(
    parameter int GROUP_SIZE    = 10,
    parameter int TRIM_EACH_END = 2,
    parameter int SAMPLE_BITS   = 12
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [ADC_W-1:0]     i_adc_sample,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [SUM_OUT_W-1:0]      o_middle_sum,
    output logic [PH_W-1:0]           o_ph_hundredths
);

    localparam int XW      = SAMPLE_BITS;
    localparam int FILL_W  = $clog2(GROUP_SIZE);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(GROUP_SIZE + 1);
    localparam int NUM_W   = SUM_W + 12;
    localparam int DIV_W   = (NUM_W > 30) ? NUM_W : 30;
    localparam int SW      = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
    localparam int MID_CNT = GROUP_SIZE - 2 * TRIM_EACH_END;
    localparam int unsigned DEN  = (MID_CNT > 0) ? PH_COUNTS * MID_CNT : PH_COUNTS;
    localparam int unsigned HALF = (MID_CNT > 0) ? DEN / 2 : 0;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DRAIN = 3'd1;
    localparam logic [2:0] ST_MULT  = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_LOAD  = 3'd5;

    logic [XW-1:0]         w_x;
    t_cell_ctl             w_ctl;
    t_link                 w_link [GROUP_SIZE];
    logic [XW-1:0]         w_val  [GROUP_SIZE];
    logic [XW-1:0]         w_next [GROUP_SIZE];
    logic [GROUP_SIZE-1:0] w_mid_mask;

    logic [2:0]            r_state;
    logic [FILL_W-1:0]     r_fill;
    logic [FILL_W-1:0]     r_idx;
    logic [XW-1:0]         r_drain [GROUP_SIZE];
    logic [SUM_W-1:0]      r_sum;
    logic [NUM_W-1:0]      r_numer;
    logic                  r_out_valid;
    logic [SUM_OUT_W-1:0]  r_out_sum;
    logic [PH_W-1:0]       r_out_ph;

    logic                  w_in_xfer;
    logic                  w_out_xfer;
    logic                  w_last;
    logic                  w_out_free;
    logic [SUM_W-1:0]      n_sum;
    logic [SW-1:0]         w_sum_ext;
    logic [SUM_OUT_W-1:0]  w_sum_sat;
    t_div_stat             w_div_stat;
    logic [PH_W-1:0]       w_quot;

    generate
        if (SAMPLE_BITS <= ADC_W) begin : g_x_trunc
            assign w_x = i_adc_sample[XW-1:0];
        end else begin : g_x_ext
            assign w_x = {{(XW - ADC_W){1'b0}}, i_adc_sample};
        end
    endgenerate

    assign w_last     = r_fill == FILL_W'(GROUP_SIZE - 1);
    assign o_in_ready = !w_last || (r_state == ST_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = r_out_valid && i_out_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_ctl.ins = w_in_xfer;
    assign w_ctl.clr = w_in_xfer && w_last;

    genvar g;
    generate
        for (g = 0; g < GROUP_SIZE; g++) begin : g_cell
            t_link         w_left;
            logic [XW-1:0] w_left_val;
            if (g == 0) begin : g_head
                assign w_left.gt    = 1'b0;
                assign w_left.valid = 1'b0;
                assign w_left_val   = '0;
            end else begin : g_body
                assign w_left     = w_link[g-1];
                assign w_left_val = w_val[g-1];
            end
            tmph_cell #(
                .W (XW)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_x          (w_x),
                .i_left       (w_left),
                .i_left_value (w_left_val),
                .o_link       (w_link[g]),
                .o_value      (w_val[g]),
                .o_next_value (w_next[g])
            );
            assign w_mid_mask[g] = (g >= TRIM_EACH_END) && (g < GROUP_SIZE - TRIM_EACH_END);
        end
    endgenerate

    assign n_sum = r_sum + (w_mid_mask[r_idx] ? SUM_W'(r_drain[0]) : SUM_W'(0));

    // sorted values shift toward the head while the middle ones are summed
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && w_ctl.clr) begin
            for (int i = 0; i < GROUP_SIZE; i++) begin
                r_drain[i] <= w_next[i];
            end
            r_sum <= '0;
        end else if (r_state == ST_DRAIN) begin
            for (int i = 0; i < GROUP_SIZE - 1; i++) begin
                r_drain[i] <= r_drain[i+1];
            end
            r_sum <= n_sum;
        end
        if (r_state == ST_MULT) begin
            r_numer <= NUM_W'(r_sum) * NUM_W'(PH_NUM) + NUM_W'(HALF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_idx   <= '0;
        end else begin
            if (w_in_xfer) begin
                r_fill <= w_last ? '0 : r_fill + FILL_W'(1);
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_ctl.clr) begin
                        r_idx   <= '0;
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_idx <= r_idx + FILL_W'(1);
                    if (r_idx == FILL_W'(GROUP_SIZE - 1)) begin
                        r_state <= ST_MULT;
                    end
                end
                ST_MULT:  r_state <= ST_START;
                ST_START: r_state <= ST_DIV;
                ST_DIV: begin
                    if (w_div_stat.done) begin
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    tmph_div #(
        .NUM_W (NUM_W),
        .DIV_W (DIV_W),
        .DEN   (DEN)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_START),
        .i_numer (r_numer),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    assign w_sum_ext = SW'(r_sum);
    assign w_sum_sat = (w_sum_ext > SW'(SUM_MAX)) ? SUM_MAX : w_sum_ext[SUM_OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_LOAD) && w_out_free) begin
            r_out_sum <= w_sum_sat;
            r_out_ph  <= w_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_LOAD) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_middle_sum    = r_out_sum;
    assign o_ph_hundredths = r_out_ph;

    `TMPH_ASSERT_IMP(a_last_when_idle, i_clk, i_rst_n, w_in_xfer && w_last, r_state == ST_IDLE)
    `TMPH_ASSERT_IMP(a_div_in_state, i_clk, i_rst_n, w_div_stat.busy || w_div_stat.done, r_state == ST_DIV)
    `TMPH_ASSERT_NXT(a_load_result, i_clk, i_rst_n, (r_state == ST_LOAD) && w_out_free, r_out_valid && (r_state == ST_IDLE))
    `TMPH_ASSERT_NXT(a_drain_done, i_clk, i_rst_n, (r_state == ST_DRAIN) && (r_idx == FILL_W'(GROUP_SIZE - 1)), r_state == ST_MULT)

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// testbench for the trimmed mean ph filter: directed and random sample groups checked against a sorting model
`timescale 1ns / 1ps

module tb_top;
    import tmph_pkg::*;

    localparam int GROUP_SIZE    = 10;
    localparam int TRIM_EACH_END = 2;
    localparam int RANDOM_GROUPS = 65;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 300;

    typedef struct packed {
        logic [SUM_OUT_W-1:0] middle_sum;
        logic [PH_W-1:0]      ph_hundredths;
    } t_ph_reading;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic [ADC_W-1:0]     i_adc_sample = '0;
    logic                 i_out_ready  = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [SUM_OUT_W-1:0] o_middle_sum;
    logic [PH_W-1:0]      o_ph_hundredths;

    logic [ADC_W-1:0] adc_stream_q [$];
    t_ph_reading      ph_readings_q [$];
    logic [ADC_W-1:0] group_buf [GROUP_SIZE];
    int               group_fill    = 0;
    int               samples_sent  = 0;
    int               samples_taken = 0;
    int               total_items   = 0;
    int               cycle_count   = 0;
    int               fail_count    = 0;
    int               stall_left    = 0;
    bit               stall_done    = 1'b0;

    wire calm = (samples_taken >= 150) && (samples_taken < 300);

    trimmed_mean_ph_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_adc_sample    (i_adc_sample),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_middle_sum    (o_middle_sum),
        .o_ph_hundredths (o_ph_hundredths)
    );

    always #5 i_clk = ~i_clk;

    task automatic log_mismatch(input string what, input int unsigned want,
                                input int unsigned seen);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch %s: expected %0d, got %0d", what, want, seen);
        end
    endtask

    // collect one sample; a full group is sorted, trimmed and scaled
    task automatic take_sample(input logic [ADC_W-1:0] sample);
        logic [ADC_W-1:0] v [GROUP_SIZE];
        logic [ADC_W-1:0] tmp;
        longint unsigned  sum;
        longint unsigned  den;
        longint unsigned  ph;
        t_ph_reading      r;
        group_buf[group_fill] = sample;
        group_fill++;
        if (group_fill == GROUP_SIZE) begin
            group_fill = 0;
            for (int i = 0; i < GROUP_SIZE; i++) v[i] = group_buf[i];
            for (int i = 0; i < GROUP_SIZE - 1; i++) begin
                for (int j = 0; j < GROUP_SIZE - 1 - i; j++) begin
                    if (v[j] > v[j+1]) begin
                        tmp    = v[j];
                        v[j]   = v[j+1];
                        v[j+1] = tmp;
                    end
                end
            end
            sum = 0;
            ph  = 0;
            if (GROUP_SIZE > 2 * TRIM_EACH_END) begin
                for (int i = TRIM_EACH_END; i < GROUP_SIZE - TRIM_EACH_END; i++) sum += v[i];
                den = longint'(PH_COUNTS) * (GROUP_SIZE - 2 * TRIM_EACH_END);
                ph  = (sum * PH_NUM + den / 2) / den;
            end
            r.middle_sum    = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_OUT_W-1:0];
            r.ph_hundredths = (ph > PH_MAX) ? PH_MAX : ph[PH_W-1:0];
            ph_readings_q.push_back(r);
        end
    endtask

    function automatic logic [ADC_W-1:0] random_sample(input int unsigned style,
                                                       input logic [ADC_W-1:0] center);
        logic [ADC_W-1:0] s;
        case (style)
            0: s = ADC_W'($urandom);
            1: s = center + ADC_W'($urandom_range(15)) - ADC_W'(8);
            2: s = $urandom_range(1) ? '1 : '0;
            default: s = ADC_W'($urandom_range(7));
        endcase
        return s;
    endfunction

    // input transfers and result checks
    always @(posedge i_clk) begin : monitor
        t_ph_reading want_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (ph_readings_q.size() == 0) begin
                log_mismatch("result with no group pending", 0, 32'(o_middle_sum));
            end else begin
                want_r = ph_readings_q.pop_front();
                if (o_middle_sum !== want_r.middle_sum) begin
                    log_mismatch("middle_sum", 32'(want_r.middle_sum), 32'(o_middle_sum));
                end
                if (o_ph_hundredths !== want_r.ph_hundredths) begin
                    log_mismatch("ph_hundredths", 32'(want_r.ph_hundredths),
                                 32'(o_ph_hundredths));
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            take_sample(i_adc_sample);
            samples_taken++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin : driver
        logic             next_valid;
        logic [ADC_W-1:0] next_sample;
        next_valid  = i_in_valid;
        next_sample = i_adc_sample;
        if (i_rst_n && !(i_in_valid && samples_sent != samples_taken)) begin
            next_valid = 1'b0;
            if (adc_stream_q.size() > 0 && (calm || $urandom_range(99) >= 10)) begin
                next_valid  = 1'b1;
                next_sample = adc_stream_q.pop_front();
                samples_sent++;
            end
        end
        i_in_valid   <= next_valid;
        i_adc_sample <= next_sample;
    end

    // long hold-off once so the block backs up and stalls its input
    always @(negedge i_clk) begin : sink
        logic next_ready;
        if (!i_rst_n) begin
            next_ready = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
        end else if (!stall_done && samples_taken >= HOLD_AT) begin
            stall_done = 1'b1;
            stall_left = HOLD_CYCLES;
            next_ready = 1'b0;
        end else begin
            next_ready = calm || ($urandom_range(99) >= 10);
        end
        i_out_ready <= next_ready;
    end

    initial begin
        int unsigned      style;
        logic [ADC_W-1:0] center;
        // full scale group, a mix of extremes, bit patterns and ties, a zero group, then random groups
        repeat (GROUP_SIZE) adc_stream_q.push_back('1);
        adc_stream_q.push_back('0);
        adc_stream_q.push_back('1);
        adc_stream_q.push_back('0);
        adc_stream_q.push_back('1);
        adc_stream_q.push_back(12'd1);
        adc_stream_q.push_back(12'd4094);
        adc_stream_q.push_back(12'd2048);
        adc_stream_q.push_back(12'd2047);
        adc_stream_q.push_back(12'hAAA);
        adc_stream_q.push_back(12'h555);
        repeat (GROUP_SIZE) adc_stream_q.push_back('0);
        for (int g = 0; g < RANDOM_GROUPS; g++) begin
            style  = $urandom_range(3);
            center = ADC_W'($urandom);
            for (int k = 0; k < GROUP_SIZE; k++) begin
                adc_stream_q.push_back(random_sample(style, center));
            end
        end
        repeat ($urandom_range(GROUP_SIZE - 1)) adc_stream_q.push_back(ADC_W'($urandom));
        total_items = adc_stream_q.size();

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (samples_taken == total_items);
        wait (ph_readings_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ph_readings_q.size() != 0) begin
            log_mismatch("group results never seen", 0, ph_readings_q.size());
        end
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
